@@ src/itrs_pkg.sv @@
// Shared types and codes for the ID-tagged reading store.
package itrs_pkg;

    localparam int ID_W    = 7;
    localparam int RES_W   = 8;
    localparam int VAL_W   = 32;
    localparam int CNT_W   = 7;
    localparam int OP_W    = 3;
    localparam int STAT_W  = 2;

    localparam logic [OP_W-1:0] OP_FETCH     = 3'd0;
    localparam logic [OP_W-1:0] OP_NEXT_UP   = 3'd1;
    localparam logic [OP_W-1:0] OP_NEXT_DOWN = 3'd2;
    localparam logic [OP_W-1:0] OP_SAVE      = 3'd3;
    localparam logic [OP_W-1:0] OP_ERASE_ALL = 3'd4;
    localparam logic [OP_W-1:0] OP_ERASE_ONE = 3'd5;

    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;
    localparam logic [STAT_W-1:0] ST_SENSOR = 2'd3;

    localparam logic [RES_W-1:0] ID_NONE = 8'hFF;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH,
        S_FETCH_RD
    } t_state;

    typedef struct packed {
        logic tag;
        logic rdg;
    } t_wr_en;

endpackage

@@ src/itrs_ram.sv @@
// Generic single-port-write, registered-read RAM.
module itrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/itrs_ctrl.sv @@
// Scan sequencer: walks the tag memory, accumulates, writes back, forms results.
module itrs_ctrl #(
    parameter int SLOTS = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic [itrs_pkg::OP_W-1:0]              i_operation,
    input  logic [itrs_pkg::ID_W-1:0]              i_target_id,
    input  logic [itrs_pkg::VAL_W-1:0]             i_reading,
    input  logic                                   i_sensor_ok,
    output logic                                   o_done,
    output logic [itrs_pkg::STAT_W-1:0]            o_status,
    output logic [itrs_pkg::RES_W-1:0]             o_result_id,
    output logic [itrs_pkg::VAL_W-1:0]             o_result_value,
    output logic [itrs_pkg::CNT_W-1:0]             o_stored_count,
    output itrs_pkg::t_wr_en                       o_wr,
    output logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] o_waddr,
    output logic [itrs_pkg::ID_W-1:0]              o_tag_wdata,
    output logic [itrs_pkg::VAL_W-1:0]             o_rdg_wdata,
    output logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] o_tag_raddr,
    output logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] o_rdg_raddr,
    input  logic [itrs_pkg::ID_W-1:0]              i_tag_rdata,
    input  logic [itrs_pkg::VAL_W-1:0]             i_rdg_rdata
);

    import itrs_pkg::*;

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [AW-1:0] LAST = AW'(SLOTS - 1);

    t_state r_state, n_state;

    logic [SLOTS-1:0]   r_valid;
    logic [CNT_W-1:0]   r_saved;
    logic [OP_W-1:0]    r_op;
    logic [ID_W-1:0]    r_tgt;
    logic [RES_W-1:0]   r_bound;
    logic [VAL_W-1:0]   r_reading;
    logic               r_ok;

    logic [AW-1:0]      r_addr;
    logic               r_issue;
    logic               r_dv;
    logic [AW-1:0]      r_daddr;
    logic               r_dlast;

    logic               r_best_v;
    logic [ID_W-1:0]    r_best_id;
    logic [AW-1:0]      r_best_addr;
    logic               r_alt_v;
    logic [ID_W-1:0]    r_alt_id;
    logic [AW-1:0]      r_alt_addr;
    logic [RES_W-1:0]   r_cur;
    logic [CNT_W-1:0]   r_cnt;

    logic               r_done;
    logic               n_done;
    logic [STAT_W-1:0]  r_status;
    logic [RES_W-1:0]   r_res_id;
    logic [VAL_W-1:0]   r_res_val;

    logic               accept;
    logic               p_valid;
    logic [ID_W-1:0]    p_tag;
    logic               p_match;
    logic               sel_v;
    logic [ID_W-1:0]    sel_id;
    logic [AW-1:0]      sel_addr;
    logic [RES_W-1:0]   nid;
    logic               save_full;
    logic               save_go;

    assign accept    = start && (r_state == S_IDLE);
    assign busy      = (r_state != S_IDLE);
    assign p_valid   = r_valid[r_daddr];
    assign p_tag     = i_tag_rdata;
    assign p_match   = r_dv && p_valid && !r_cur[RES_W-1] && (p_tag == r_cur[ID_W-1:0]);
    assign sel_v     = r_best_v || r_alt_v;
    assign sel_id    = r_best_v ? r_best_id : r_alt_id;
    assign sel_addr  = r_best_v ? r_best_addr : r_alt_addr;
    assign nid       = r_alt_v ? ({1'b0, r_alt_id} + RES_W'(1)) : '0;
    assign save_full = !r_best_v || nid[RES_W-1];
    assign save_go   = (r_state == S_FINISH) && (r_op == OP_SAVE) && !save_full && r_ok;

    assign n_done = (accept && ((i_operation == OP_ERASE_ALL) || (i_operation > OP_ERASE_ONE)))
                 || ((r_state == S_FINISH) && !((r_op == OP_FETCH) && sel_v))
                 || (r_state == S_FETCH_RD);

    assign o_tag_raddr = r_addr;
    assign o_rdg_raddr = sel_addr;
    assign o_waddr     = r_best_addr;
    assign o_tag_wdata = nid[ID_W-1:0];
    assign o_rdg_wdata = r_reading;
    assign o_wr.tag    = save_go;
    assign o_wr.rdg    = save_go;

    assign o_done         = r_done;
    assign o_status       = r_status;
    assign o_result_id    = r_res_id;
    assign o_result_value = r_res_val;
    assign o_stored_count = r_saved;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && (i_operation != OP_ERASE_ALL) && (i_operation <= OP_ERASE_ONE)) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_dv && r_dlast) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if ((r_op == OP_FETCH) && sel_v) begin
                    n_state = S_FETCH_RD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_FETCH_RD: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // scan pipeline and accumulators
    always_ff @(posedge i_clk) begin
        r_dv <= i_rst_n && (r_state == S_SCAN) && r_issue;
        if (r_state == S_IDLE && accept) begin
            r_op        <= i_operation;
            r_tgt       <= i_target_id;
            r_bound     <= (i_operation == OP_FETCH) ? {1'b0, i_target_id}
                                                     : ({1'b0, i_target_id} + RES_W'(1));
            r_reading   <= i_reading;
            r_ok        <= i_sensor_ok;
            r_addr      <= '0;
            r_best_v    <= 1'b0;
            r_alt_v     <= 1'b0;
            r_best_id   <= '0;
            r_alt_id    <= '0;
            r_best_addr <= '0;
            r_alt_addr  <= '0;
            r_cur       <= {1'b0, i_target_id};
            r_cnt       <= '0;
        end
        if (r_state == S_SCAN && r_issue) begin
            r_daddr <= r_addr;
            r_dlast <= (r_addr == LAST);
            if (r_addr != LAST) begin
                r_addr <= r_addr + AW'(1);
            end
        end
        if (r_dv) begin
            case (r_op) inside
                OP_FETCH, OP_NEXT_UP: begin
                    if (p_valid && ({1'b0, p_tag} >= r_bound)
                        && (!r_best_v || p_tag < r_best_id)) begin
                        r_best_v    <= 1'b1;
                        r_best_id   <= p_tag;
                        r_best_addr <= r_daddr;
                    end
                    if (p_valid && (!r_alt_v || p_tag < r_alt_id)) begin
                        r_alt_v    <= 1'b1;
                        r_alt_id   <= p_tag;
                        r_alt_addr <= r_daddr;
                    end
                end
                OP_NEXT_DOWN: begin
                    if (p_valid && (p_tag < r_tgt) && (!r_best_v || p_tag > r_best_id)) begin
                        r_best_v    <= 1'b1;
                        r_best_id   <= p_tag;
                        r_best_addr <= r_daddr;
                    end
                    if (p_valid && (!r_alt_v || p_tag > r_alt_id)) begin
                        r_alt_v    <= 1'b1;
                        r_alt_id   <= p_tag;
                        r_alt_addr <= r_daddr;
                    end
                end
                OP_SAVE: begin
                    if (!p_valid && !r_best_v) begin
                        r_best_v    <= 1'b1;
                        r_best_addr <= r_daddr;
                    end
                    if (p_valid && (!r_alt_v || p_tag > r_alt_id)) begin
                        r_alt_v    <= 1'b1;
                        r_alt_id   <= p_tag;
                        r_alt_addr <= r_daddr;
                    end
                end
                OP_ERASE_ONE: begin
                    if (p_match) begin
                        r_cur <= r_cur - RES_W'(1);
                    end
                    if (p_valid && !p_match) begin
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // issue flag, valid bits, saved count and result beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue <= 1'b0;
            r_valid <= '0;
            r_saved <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= n_done;
            if (accept) begin
                r_issue <= 1'b1;
            end else if (r_state == S_SCAN && r_addr == LAST) begin
                r_issue <= 1'b0;
            end
            if (p_match && r_op == OP_ERASE_ONE) begin
                r_valid[r_daddr] <= 1'b0;
            end
            if (save_go) begin
                r_valid[r_best_addr] <= 1'b1;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept && i_operation == OP_ERASE_ALL) begin
                        r_valid   <= '0;
                        r_saved   <= '0;
                        r_status  <= ST_OK;
                        r_res_id  <= '0;
                        r_res_val <= '0;
                    end else if (accept && i_operation > OP_ERASE_ONE) begin
                        r_status  <= ST_OK;
                        r_res_id  <= ID_NONE;
                        r_res_val <= '0;
                    end
                end
                S_SCAN: begin
                end
                S_FINISH: begin
                    r_res_val <= '0;
                    case (r_op) inside
                        OP_FETCH, OP_NEXT_UP, OP_NEXT_DOWN: begin
                            r_status <= sel_v ? ST_OK : ST_EMPTY;
                            r_res_id <= sel_v ? {1'b0, sel_id} : ID_NONE;
                        end
                        OP_SAVE: begin
                            if (save_full) begin
                                r_status <= ST_FULL;
                                r_res_id <= ID_NONE;
                            end else if (!r_ok) begin
                                r_status <= ST_SENSOR;
                                r_res_id <= ID_NONE;
                            end else begin
                                r_status <= ST_OK;
                                r_res_id <= nid;
                                r_saved  <= r_saved + CNT_W'(1);
                            end
                        end
                        default: begin
                            r_status <= ST_OK;
                            r_res_id <= r_cur;
                            r_saved  <= r_cnt;
                        end
                    endcase
                end
                S_FETCH_RD: begin
                    r_res_val <= i_rdg_rdata;
                end
                default: begin
                end
            endcase
        end
    end

endmodule

@@ src/id_tagged_reading_store_core.sv @@
// Top level of the ID-tagged reading store: tag and reading memories plus scan control.
//
//  channel   | handshake          | beat fields
//  ----------+--------------------+---------------------------------------------------
//  command   | start / busy       | i_operation, i_target_id, i_reading, i_sensor_ok
//  result    | o_done (strobe)    | o_status, o_result_id, o_result_value, o_stored_count
//
// Fetch, next-up, next-down, save and erase-one scan the tag memory one slot per cycle;
// o_done rises after the finish step, or for a fetch that finds a reading after one more
// read of the reading memory. Erase-all and unused codes answer on the next cycle. Reset
// empties the store at once through per-slot valid bits; no clear pass. busy is high in
// the scan, finish and read steps; the result strobe lasts one cycle and cannot be held.
module id_tagged_reading_store_core #(
    parameter int SLOTS = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [itrs_pkg::OP_W-1:0]        i_operation,
    input  logic [itrs_pkg::ID_W-1:0]        i_target_id,
    input  logic [itrs_pkg::VAL_W-1:0]       i_reading,
    input  logic                             i_sensor_ok,
    output logic                             o_done,
    output logic [itrs_pkg::STAT_W-1:0]      o_status,
    output logic [itrs_pkg::RES_W-1:0]       o_result_id,
    output logic [itrs_pkg::VAL_W-1:0]       o_result_value,
    output logic [itrs_pkg::CNT_W-1:0]       o_stored_count
);

    import itrs_pkg::*;

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    t_wr_en          wr;
    logic [AW-1:0]   waddr;
    logic [ID_W-1:0] tag_wdata;
    logic [VAL_W-1:0] rdg_wdata;
    logic [AW-1:0]   tag_raddr;
    logic [AW-1:0]   rdg_raddr;
    logic [ID_W-1:0] tag_rdata;
    logic [VAL_W-1:0] rdg_rdata;

    itrs_ram #(
        .WIDTH (ID_W),
        .DEPTH (SLOTS)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (wr.tag),
        .i_waddr (waddr),
        .i_wdata (tag_wdata),
        .i_raddr (tag_raddr),
        .o_rdata (tag_rdata)
    );

    itrs_ram #(
        .WIDTH (VAL_W),
        .DEPTH (SLOTS)
    ) u_rdg_ram (
        .i_clk   (i_clk),
        .i_we    (wr.rdg),
        .i_waddr (waddr),
        .i_wdata (rdg_wdata),
        .i_raddr (rdg_raddr),
        .o_rdata (rdg_rdata)
    );

    itrs_ctrl #(
        .SLOTS (SLOTS)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_operation    (i_operation),
        .i_target_id    (i_target_id),
        .i_reading      (i_reading),
        .i_sensor_ok    (i_sensor_ok),
        .o_done         (o_done),
        .o_status       (o_status),
        .o_result_id    (o_result_id),
        .o_result_value (o_result_value),
        .o_stored_count (o_stored_count),
        .o_wr           (wr),
        .o_waddr        (waddr),
        .o_tag_wdata    (tag_wdata),
        .o_rdg_wdata    (rdg_wdata),
        .o_tag_raddr    (tag_raddr),
        .o_rdg_raddr    (rdg_raddr),
        .i_tag_rdata    (tag_rdata),
        .i_rdg_rdata    (rdg_rdata)
    );

endmodule
